// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the motor ramp checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSRR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSRR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/msrr_pkg.sv =====
// ----------------------------------------------------------------------------
// msrr_pkg
// Types, constants and helpers for the motor speed ramp reverser.
// ----------------------------------------------------------------------------
package msrr_pkg;

  // Tick rate of the millisecond timebase
  localparam int unsigned TICKS_PER_SECOND = 1000;

  localparam int unsigned DUTY_W = 8;
  localparam int unsigned RATE_W = 10;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(RATE_W + 1);

  // Response queue between datapath and output channel
  localparam int unsigned RSP_BUF_DEPTH = 2;
  localparam int unsigned RSP_PTR_W = $clog2(RSP_BUF_DEPTH);
  localparam int unsigned RSP_CNT_W = $clog2(RSP_BUF_DEPTH + 1);

  typedef logic [DUTY_W-1:0]    duty_t;
  typedef logic [RATE_W-1:0]    rate_t;
  typedef logic [TICK_W-1:0]    ticks_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam rate_t  DIVIDEND    = RATE_W'(TICKS_PER_SECOND);
  localparam ticks_t ELAPSED_MAX = {TICK_W{1'b1}};

  // Register indexes on the configuration channel
  localparam cfg_idx_t CFG_DUTY_FLOOR   = CFG_IDX_W'(0);
  localparam cfg_idx_t CFG_DUTY_CEILING = CFG_IDX_W'(1);

  typedef enum logic {
    KIND_COMMAND = 1'b0,
    KIND_TICK    = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic tick_exec;
    logic cmd_load;
    logic cmd_finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  typedef struct packed {
    logic  out_direction;
    duty_t out_duty;
    logic  out_written;
    logic  ramp_active;
  } rsp_t;

  // Floor test comes first: with crossed limits, values up to the floor get the floor and values above it the ceiling
  function automatic duty_t clamp_duty(duty_t want, duty_t floor_v, duty_t ceil_v);
    duty_t res;
    if (want <= floor_v) begin
      res = floor_v;
    end else if (want >= ceil_v) begin
      res = ceil_v;
    end else begin
      res = want;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/msrr_ifs.sv =====
// ----------------------------------------------------------------------------
// msrr channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface msrr_req_if import msrr_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_e kind;
  logic  drive_direction;
  duty_t target_duty;
  rate_t step_rate;

  modport source (output valid, kind, drive_direction, target_duty, step_rate,
                  input ready);
  modport sink   (input valid, kind, drive_direction, target_duty, step_rate,
                  output ready);
endinterface

interface msrr_rsp_if import msrr_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  out_direction;
  duty_t out_duty;
  logic  out_written;
  logic  ramp_active;

  modport source (output valid, out_direction, out_duty, out_written, ramp_active,
                  input ready);
  modport sink   (input valid, out_direction, out_duty, out_written, ramp_active,
                  output ready);
endinterface

interface msrr_cfg_if import msrr_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  duty_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/msrr_div.sv =====
// ----------------------------------------------------------------------------
// msrr_div
// Restoring divider: TICKS_PER_SECOND / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msrr_div import msrr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  rate_t divisor_i,
  output logic  done_o,
  output rate_t quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  rate_t                dsr_q, dsr_d;
  rate_t                rem_q, rem_d;
  rate_t                quo_q, quo_d;
  logic [RATE_W:0]      trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[RATE_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(RATE_W);
      dsr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = DIVIDEND;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = RATE_W'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[RATE_W-2:0], 1'b1};
      end else begin
        rem_d = trial[RATE_W-1:0];
        quo_d = {quo_q[RATE_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/msrr_dp.sv =====
// ----------------------------------------------------------------------------
// msrr_dp
// Ramp datapath: config registers, ramp state, tick step logic, divider.
// ----------------------------------------------------------------------------
module msrr_dp import msrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  input  logic     req_direction_i,
  input  duty_t    req_duty_i,
  input  rate_t    req_rate_i,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  duty_t    cfg_data_i,
  output logic     res_push_o,
  output rsp_t     res_o
);

  duty_t  floor_q, floor_d;
  duty_t  ceil_q, ceil_d;
  duty_t  pres_duty_q, pres_duty_d;
  logic   pres_dir_q, pres_dir_d;
  duty_t  goal_duty_q, goal_duty_d;
  logic   goal_dir_q, goal_dir_d;
  ticks_t interval_q, interval_d;
  ticks_t elapsed_q, elapsed_d;
  logic   ramping_q, ramping_d;
  logic   drv_dir_q, drv_dir_d;
  duty_t  drv_duty_q, drv_duty_d;

  ticks_t elapsed_inc;
  logic   written;
  rate_t  divisor;
  logic   div_done;
  rate_t  quotient;

  // Rate zero counts as one step per second
  assign divisor = (req_rate_i == '0) ? RATE_W'(1) : req_rate_i;

  msrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cmd_load),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.div_done = div_done;

  // Saturating elapsed count
  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + TICK_W'(1) : elapsed_q;

  // Next-state logic for config writes, ticks and commands
  always_comb begin
    floor_d     = floor_q;
    ceil_d      = ceil_q;
    pres_duty_d = pres_duty_q;
    pres_dir_d  = pres_dir_q;
    goal_duty_d = goal_duty_q;
    goal_dir_d  = goal_dir_q;
    interval_d  = interval_q;
    elapsed_d   = elapsed_q;
    ramping_d   = ramping_q;
    drv_dir_d   = drv_dir_q;
    drv_duty_d  = drv_duty_q;
    written     = 1'b0;

    if (cfg_we_i && cfg_idx_i == CFG_DUTY_FLOOR) begin
      floor_d = cfg_data_i;
    end
    if (cfg_we_i && cfg_idx_i == CFG_DUTY_CEILING) begin
      ceil_d = cfg_data_i;
    end

    if (cmd_i.tick_exec) begin
      elapsed_d = elapsed_inc;
      if (ramping_q && elapsed_inc >= interval_q) begin
        elapsed_d = '0;
        if (pres_dir_q == goal_dir_q) begin
          if (pres_duty_q == goal_duty_q) begin
            ramping_d = 1'b0;
          end else if (pres_duty_q > goal_duty_q) begin
            pres_duty_d = pres_duty_q - DUTY_W'(1);
          end else begin
            pres_duty_d = pres_duty_q + DUTY_W'(1);
          end
          written = 1'b1;
        end else if (pres_duty_q == '0) begin
          // at standstill: flip direction, drive nothing this tick
          pres_dir_d = ~pres_dir_q;
        end else begin
          pres_duty_d = pres_duty_q - DUTY_W'(1);
          written     = 1'b1;
        end
        if (written) begin
          drv_dir_d  = pres_dir_d;
          drv_duty_d = pres_duty_d;
        end
      end
    end

    if (cmd_i.cmd_load) begin
      goal_dir_d  = req_direction_i;
      goal_duty_d = clamp_duty(req_duty_i, floor_q, ceil_q);
    end

    if (cmd_i.cmd_finish) begin
      interval_d = quotient;
      ramping_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= '0;
      ceil_q      <= '1;
      pres_duty_q <= '0;
      pres_dir_q  <= 1'b1;
      goal_duty_q <= '0;
      goal_dir_q  <= 1'b1;
      interval_q  <= '0;
      elapsed_q   <= '0;
      ramping_q   <= 1'b0;
      drv_dir_q   <= 1'b1;
      drv_duty_q  <= '0;
    end else begin
      floor_q     <= floor_d;
      ceil_q      <= ceil_d;
      pres_duty_q <= pres_duty_d;
      pres_dir_q  <= pres_dir_d;
      goal_duty_q <= goal_duty_d;
      goal_dir_q  <= goal_dir_d;
      interval_q  <= interval_d;
      elapsed_q   <= elapsed_d;
      ramping_q   <= ramping_d;
      drv_dir_q   <= drv_dir_d;
      drv_duty_q  <= drv_duty_d;
    end
  end

  // Result of the finishing item
  assign res_push_o          = cmd_i.tick_exec | cmd_i.cmd_finish;
  assign res_o.out_direction = drv_dir_d;
  assign res_o.out_duty      = drv_duty_d;
  assign res_o.out_written   = written;
  assign res_o.ramp_active   = ramping_d;

endmodule

// ===== hw/rtl/msrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// msrr_ctrl
// Controller: accepts requests and sequences the interval division.
// ----------------------------------------------------------------------------
module msrr_ctrl import msrr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  kind_e   req_kind_i,
  output logic    req_ready_o,
  input  logic    buf_full_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = !buf_full_i;
        if (req_valid_i && !buf_full_i) begin
          if (req_kind_i == KIND_TICK) begin
            cmd_o.tick_exec = 1'b1;
          end else begin
            cmd_o.cmd_load = 1'b1;
            state_d        = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          cmd_o.cmd_finish = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/msrr_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// msrr_rsp_buf
// Small response queue decoupling the datapath from the output channel.
// ----------------------------------------------------------------------------
module msrr_rsp_buf import msrr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rsp_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output rsp_t data_o
);

  rsp_t                 mem_q [RSP_BUF_DEPTH];
  logic [RSP_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RSP_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RSP_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == RSP_CNT_W'(RSP_BUF_DEPTH));
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + RSP_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + RSP_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + RSP_CNT_W'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - RSP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/motor_speed_ramp_reverser.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_reverser
// Soft-start PWM duty ramp generator for a reversible motor bridge.
// ----------------------------------------------------------------------------
// Channels: req_i takes either a ramp command (kind 0: direction, target duty,
// steps per second) or a one millisecond tick (kind 1). Every request yields
// exactly one response on rsp_o with the drive last written to the bridge,
// whether this request rewrote it, and whether a ramp is still running.
// cfg_i writes the duty floor (index 0) and ceiling (index 1); it is always
// ready and other indexes are dropped. Write it only while the block is idle.
// Timing: a tick's response is valid in the cycle after the tick is taken.
// A command runs the interval division 1000 / rate through a
// one-bit-per-cycle divider; its response is queued when the divider is done,
// and the next request is taken after that. Ticks sustain one per cycle while
// the queue has room. Stalls: up to two responses queue; requests are held off
// while the queue is full and while a command is dividing. Reset restores the
// floor 0, ceiling 255, duty 0, forward direction and no active ramp.
// ----------------------------------------------------------------------------
module motor_speed_ramp_reverser import msrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  msrr_req_if.sink   req_i,
  msrr_rsp_if.source rsp_o,
  msrr_cfg_if.sink   cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    buf_full;
  logic    res_push;
  rsp_t    res;
  rsp_t    rsp_head;
  logic    rsp_valid;

  assign cfg_i.ready = 1'b1;

  msrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .buf_full_i  (buf_full),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msrr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_direction_i (req_i.drive_direction),
    .req_duty_i      (req_i.target_duty),
    .req_rate_i      (req_i.step_rate),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .res_push_o      (res_push),
    .res_o           (res)
  );

  msrr_rsp_buf u_rsp_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .pop_i   (rsp_o.ready),
    .valid_o (rsp_valid),
    .full_o  (buf_full),
    .data_o  (rsp_head)
  );

  // Output channel from the queue head
  assign rsp_o.valid         = rsp_valid;
  assign rsp_o.out_direction = rsp_head.out_direction;
  assign rsp_o.out_duty      = rsp_head.out_duty;
  assign rsp_o.out_written   = rsp_head.out_written;
  assign rsp_o.ramp_active   = rsp_head.ramp_active;

endmodule

// ===== hw/rtl/msrr_checker.sv =====
// ----------------------------------------------------------------------------
// msrr_checker
// Port-level checks on the ramp generator's request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msrr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_direction_i,
  input logic [7:0] rsp_duty_i,
  input logic       rsp_written_i,
  input logic       rsp_active_i
);

  logic        req_hs;
  logic        rsp_hs;
  logic [1:0]  pend_q, pend_d;
  logic        last_dir_q;
  logic [7:0]  last_duty_q;
  logic [7:0]  duty_dist;
  logic [10:0] rsp_payload;
  logic [10:0] payload_q;
  logic        stall_q;
  logic        rsp_held;
  logic        rsp_lone;
  logic        rsp_unwritten;
  logic        rsp_stepped;
  logic        drive_kept;

  assign req_hs      = req_valid_i && req_ready_i;
  assign rsp_hs      = rsp_valid_i && rsp_ready_i;
  assign rsp_payload = {rsp_direction_i, rsp_duty_i, rsp_written_i, rsp_active_i};

  // Requests still owed a response
  always_comb begin
    pend_d = pend_q;
    if (req_hs && !rsp_hs) begin
      pend_d = pend_q + 2'd1;
    end else if (rsp_hs && !req_hs) begin
      pend_d = pend_q - 2'd1;
    end
  end

  // Pending count, drive last seen on the response channel, previous-cycle stall state and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      last_dir_q  <= 1'b1;
      last_duty_q <= '0;
      stall_q     <= 1'b0;
      payload_q   <= '0;
    end else begin
      pend_q    <= pend_d;
      stall_q   <= rsp_valid_i && !rsp_ready_i;
      payload_q <= rsp_payload;
      if (rsp_hs) begin
        last_dir_q  <= rsp_direction_i;
        last_duty_q <= rsp_duty_i;
      end
    end
  end

  assign duty_dist = (rsp_duty_i >= last_duty_q) ? rsp_duty_i - last_duty_q
                                                 : last_duty_q - rsp_duty_i;

  assign rsp_held      = rsp_valid_i && (rsp_payload == payload_q);
  assign rsp_lone      = rsp_hs && !req_hs;
  assign rsp_unwritten = rsp_hs && !rsp_written_i;
  assign rsp_stepped   = rsp_hs && rsp_written_i;
  assign drive_kept    = (rsp_duty_i == last_duty_q) && (rsp_direction_i == last_dir_q);

  `MSRR_ASSERT_IMP(a_rsp_hold, clk_i, rst_ni, stall_q, rsp_held, "stalled response changed")

  `MSRR_ASSERT_IMP(a_no_extra_rsp, clk_i, rst_ni, rsp_lone, pend_q != 2'd0, "response unrequested")

  `MSRR_ASSERT_IMP(a_unwritten_keeps, clk_i, rst_ni, rsp_unwritten, drive_kept, "drive changed")

  `MSRR_ASSERT_IMP(a_single_step, clk_i, rst_ni, rsp_stepped, duty_dist <= 8'd1, "duty jumped")

endmodule

bind motor_speed_ramp_reverser msrr_checker u_msrr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_direction_i (rsp_o.out_direction),
  .rsp_duty_i      (rsp_o.out_duty),
  .rsp_written_i   (rsp_o.out_written),
  .rsp_active_i    (rsp_o.ramp_active)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor speed ramp reverser: commands and
// millisecond ticks go in with random gaps, each response is compared field
// by field against an in-bench prediction of the duty ramp.
// ----------------------------------------------------------------------------

// Predicts the drive after every request and checks responses in order
class ramp_scoreboard;
  msrr_pkg::duty_t  duty_floor, duty_ceiling;
  msrr_pkg::duty_t  cur_duty, goal_duty, bridge_duty;
  logic             cur_dir, goal_dir, bridge_dir;
  msrr_pkg::ticks_t step_gap, elapsed;
  bit               ramping;
  msrr_pkg::rsp_t   pending_rsp[$];
  int unsigned      mismatches, commands, ticks, drive_writes, flips;
  int unsigned      reg_writes, checked;

  function new();
    duty_floor   = '0;
    duty_ceiling = '1;
    cur_duty     = '0;
    goal_duty    = '0;
    bridge_duty  = '0;
    cur_dir      = 1'b1;
    goal_dir     = 1'b1;
    bridge_dir   = 1'b1;
    step_gap     = '0;
    elapsed      = '0;
    ramping      = 1'b0;
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  function void write_register(msrr_pkg::cfg_idx_t idx, msrr_pkg::duty_t val);
    reg_writes++;
    if (idx == msrr_pkg::CFG_DUTY_FLOOR) begin
      duty_floor = val;
    end else if (idx == msrr_pkg::CFG_DUTY_CEILING) begin
      duty_ceiling = val;
    end
  endfunction

  // Advance the ramp state for one accepted request, queue the drive it yields
  function void note_request(msrr_pkg::kind_e kind, logic dir, msrr_pkg::duty_t duty,
                             msrr_pkg::rate_t rate);
    int unsigned    steps_per_s;
    bit             wrote;
    msrr_pkg::rsp_t want;
    wrote = 1'b0;
    if (kind == msrr_pkg::KIND_COMMAND) begin
      commands++;
      goal_dir = dir;
      // floor test comes first, so crossed limits favor the ceiling above it
      if (duty <= duty_floor) begin
        goal_duty = duty_floor;
      end else if (duty >= duty_ceiling) begin
        goal_duty = duty_ceiling;
      end else begin
        goal_duty = duty;
      end
      steps_per_s = (rate == 0) ? 1 : rate;
      step_gap    = msrr_pkg::ticks_t'(msrr_pkg::TICKS_PER_SECOND / steps_per_s);
      ramping     = 1'b1;
    end else begin
      ticks++;
      if (elapsed != msrr_pkg::ELAPSED_MAX) begin
        elapsed++;
      end
      if (ramping && elapsed >= step_gap) begin
        if (cur_dir == goal_dir) begin
          // at the goal: one last drive, then the ramp ends
          if (cur_duty == goal_duty) begin
            ramping = 1'b0;
          end else if (cur_duty > goal_duty) begin
            cur_duty--;
          end else begin
            cur_duty++;
          end
          wrote = 1'b1;
        end else if (cur_duty == 0) begin
          // reversal at standstill drives nothing
          cur_dir = ~cur_dir;
          flips++;
        end else begin
          cur_duty--;
          wrote = 1'b1;
        end
        elapsed = '0;
      end
    end
    if (wrote) begin
      bridge_dir  = cur_dir;
      bridge_duty = cur_duty;
      drive_writes++;
    end
    want.out_direction = bridge_dir;
    want.out_duty      = bridge_duty;
    want.out_written   = wrote;
    want.ramp_active   = ramping;
    pending_rsp.push_back(want);
  endfunction

  function void check_response(msrr_pkg::rsp_t got);
    msrr_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      flag($sformatf("response with nothing pending: dir %0d duty %0d wr %0d act %0d",
                     got.out_direction, got.out_duty, got.out_written, got.ramp_active));
      return;
    end
    want = pending_rsp.pop_front();
    checked++;
    if (got.out_direction !== want.out_direction || got.out_duty !== want.out_duty ||
        got.out_written !== want.out_written || got.ramp_active !== want.ramp_active) begin
      flag($sformatf("response %0d exp dir %0d duty %0d wr %0d act %0d, got dir %0d duty %0d wr %0d act %0d",
                     checked, want.out_direction, want.out_duty, want.out_written,
                     want.ramp_active, got.out_direction, got.out_duty, got.out_written,
                     got.ramp_active));
    end
  endfunction

  function void close_out();
    while (pending_rsp.size() != 0) begin
      void'(pending_rsp.pop_front());
      flag("expected response never arrived");
    end
  endfunction
endclass

module tb;
  import msrr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic clk_i;
  logic rst_ni;

  msrr_req_if req();
  msrr_rsp_if rsp();
  msrr_cfg_if cfg();

  motor_speed_ramp_reverser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  ramp_scoreboard sb;
  bit             idling;
  int unsigned    stall_left;
  int unsigned    sent_items;
  int unsigned    cycle_count;

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d responses outstanding", $time, sb.pending_rsp.size());
      $display("status: fail");
      $finish;
    end
  end

  // Monitor: response checked before the same-edge request is noted
  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready) begin
      sb.check_response('{rsp.out_direction, rsp.out_duty, rsp.out_written, rsp.ramp_active});
    end
    if (req.valid && req.ready) begin
      sb.note_request(req.kind, req.drive_direction, req.target_duty, req.step_rate);
    end
    if (cfg.valid && cfg.ready) begin
      sb.write_register(cfg.index, cfg.data);
    end
  end

  // Response sink with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left == 0 && idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left != 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // One request; returns at the falling edge after it was taken
  task automatic send_item(kind_e kind, logic dir, duty_t duty, rate_t rate);
    if (idling && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    req.valid           <= 1'b1;
    req.kind            <= kind;
    req.drive_direction <= dir;
    req.target_duty     <= duty;
    req.step_rate       <= rate;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    sent_items++;
  endtask

  // Ticks carry random junk in the unused fields
  task automatic send_ticks(int unsigned n);
    repeat (n) begin
      send_item(KIND_TICK, 1'($urandom), duty_t'($urandom), rate_t'($urandom));
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  // Both limits, written back to back while the block is idle
  task automatic write_limits(duty_t floor_v, duty_t ceil_v);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_DUTY_FLOOR;
    cfg.data  <= floor_v;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.index <= CFG_DUTY_CEILING;
    cfg.data  <= ceil_v;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  function automatic duty_t pick_limit(duty_t lo, duty_t hi);
    duty_t v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2:       v = duty_t'($urandom);
      default: v = duty_t'($urandom_range(lo, hi));
    endcase
    return v;
  endfunction

  function automatic rate_t pick_rate();
    rate_t r;
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = rate_t'($urandom_range(1, 9));
      2:       r = rate_t'($urandom_range(1001, 1023));
      3:       r = rate_t'($urandom_range(10, 99));
      default: r = rate_t'($urandom_range(100, 1000));
    endcase
    return r;
  endfunction

  initial begin
    int unsigned next_phase;
    int unsigned burst;
    logic        dir;
    sb = new();
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    req.valid           = 1'b0;
    req.kind            = KIND_TICK;
    req.drive_direction = 1'b0;
    req.target_duty     = '0;
    req.step_rate       = '0;
    rsp.ready           = 1'b1;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_DUTY_FLOOR;
    cfg.data            = '0;
    idling              = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, ramp up, ramp to goal, reversal, back-to-back commands
    send_ticks(1);
    send_item(KIND_COMMAND, 1'b1, 8'd255, 10'd1000);
    send_ticks(3);
    send_item(KIND_COMMAND, 1'b1, 8'd2, 10'd1001);
    send_ticks(3);
    send_item(KIND_COMMAND, 1'b0, 8'd255, 10'd1023);
    send_ticks(5);
    send_item(KIND_COMMAND, 1'b0, 8'd0, 10'd0);
    send_item(KIND_COMMAND, 1'b1, 8'd0, 10'd512);
    send_ticks(4);

    // Crossed limits: floor above ceiling
    drain();
    write_limits(8'd200, 8'd50);
    send_item(KIND_COMMAND, 1'b1, 8'd100, 10'd700);
    send_ticks(2);
    send_item(KIND_COMMAND, 1'b1, 8'd200, 10'd1000);
    send_ticks(1);
    send_item(KIND_COMMAND, 1'b1, 8'd0, 10'd1023);
    send_ticks(1);

    // Settle the ramp, idle long enough to saturate the tick counter,
    // then a one-step-per-second command must step on the very next tick
    drain();
    write_limits(8'd0, 8'd255);
    send_item(KIND_COMMAND, sb.cur_dir, sb.cur_duty, 10'd1000);
    while (sb.ramping) send_ticks(1);
    idling = 1'b0;
    send_ticks(1030);
    send_item(KIND_COMMAND, sb.cur_dir, sb.cur_duty ^ 8'd1, 10'd1);
    send_ticks(2);

    // Random ramps in phases, limits rewritten between phases
    sent_items = 0;
    next_phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items >= next_phase) begin
        drain();
        if ($urandom_range(0, 3) == 0) begin
          write_limits(pick_limit(0, 255), pick_limit(0, 255));
        end else begin
          write_limits(pick_limit(0, 60), pick_limit(180, 255));
        end
        next_phase = sent_items + PHASE_ITEMS;
        idling = (sent_items < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 4) != 0);
      end
      if ($urandom_range(0, 19) != 0) begin
        dir = ($urandom_range(0, 9) < 4) ? ~sb.cur_dir : sb.cur_dir;
        send_item(KIND_COMMAND, dir, duty_t'($urandom), pick_rate());
      end
      case ($urandom_range(0, 9))
        0:       burst = 0;
        1:       burst = $urandom_range(40, 80);
        default: burst = $urandom_range(1, 40);
      endcase
      send_ticks(burst);
    end

    drain();
    repeat (16) @(negedge clk_i);
    sb.close_out();
    $display("covered %0d requests: %0d commands, %0d ticks, %0d register writes",
             sb.commands + sb.ticks, sb.commands, sb.ticks, sb.reg_writes);
    $display("%0d responses checked, %0d drive updates, %0d reversals, %0d mismatches",
             sb.checked, sb.drive_writes, sb.flips, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/msrr_pkg.sv
hw/rtl/msrr_ifs.sv
hw/rtl/msrr_div.sv
hw/rtl/msrr_dp.sv
hw/rtl/msrr_ctrl.sv
hw/rtl/msrr_rsp_buf.sv
hw/rtl/motor_speed_ramp_reverser.sv
hw/rtl/msrr_checker.sv
bench/tb.sv
